### rtl/ordered_list_delete_by_key_defines.svh
`ifndef ORDERED_LIST_DELETE_BY_KEY_DEFINES_SVH
`define ORDERED_LIST_DELETE_BY_KEY_DEFINES_SVH

// a must be followed by b in the same cycle
`define OLDBK_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("oldbk: same-cycle check failed");

// a must be followed by b in the next cycle
`define OLDBK_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("oldbk: next-cycle check failed");

`endif

### rtl/oldbk_pkg.sv
package oldbk_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CmdW    = 2;

  localparam logic [CmdW-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_DISPLAY = 2'd2;

  localparam logic [StatusW-1:0] STS_APPENDED  = 3'd0;
  localparam logic [StatusW-1:0] STS_FULL      = 3'd1;
  localparam logic [StatusW-1:0] STS_DELETED   = 3'd2;
  localparam logic [StatusW-1:0] STS_NOT_FOUND = 3'd3;
  localparam logic [StatusW-1:0] STS_SHOWN     = 3'd4;
  localparam logic [StatusW-1:0] STS_EMPTY     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SHOW = 2'b10
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              append;
    logic              delete_en;
    logic              rotate;
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

### rtl/oldbk_cell.sv
module oldbk_cell import oldbk_pkg::*; #(
  parameter int Depth = 16,
  parameter int Idx   = 0,
  localparam int CW   = $clog2(Depth + 1)
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CW-1:0]     count_i,
  input  logic [ValueW-1:0] next_i,
  input  logic [ValueW-1:0] head_i,
  input  logic              hit_i,
  output logic              hit_o,
  output logic              first_o,
  output logic [ValueW-1:0] value_o
);

  logic [ValueW-1:0] value_q, value_d;
  logic              occupied;
  logic              hit_self;
  logic              is_tail;

  assign occupied = CW'(Idx) < count_i;
  assign hit_self = occupied && (value_q == ctrl_i.value);
  assign is_tail  = CW'(Idx + 1) == count_i;
  assign hit_o    = hit_i | hit_self;
  assign first_o  = hit_self & ~hit_i;
  assign value_o  = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.append && (CW'(Idx) == count_i)) begin
      value_d = ctrl_i.value;
    end else if (ctrl_i.delete_en && hit_o) begin
      value_d = next_i;
    end else if (ctrl_i.rotate) begin
      value_d = is_tail ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

### rtl/ordered_list_delete_by_key.sv
// Ordered list of up to Depth signed 32-bit values, held in a chain of cells.
// Command channel: a request is taken at a rising edge with start high and
// busy low; cmd_i picks append (0), delete first match of the key (1) or
// display (2); code 3 is dropped without a result.
// Result channel: each result shows on status_o, element_o, position_o and
// last_o for one cycle, marked by strobe_o. The receiver cannot stall; every
// result is taken in the cycle it is shown.
// Append and delete: one result, registered and shown in the cycle after the
// request; busy stays low, so a new request may follow in every cycle.
// Display: count results (one when empty), one per cycle, each registered from
// the head cell after the request moves the state to ST_SHOW (the empty result
// shows in the cycle after the request); the chain rotates one place per cycle,
// so busy is high in ST_SHOW and drops in the cycle that shows the last result.
// Delete compares all cells at once and shifts the tail side up by one.
// Reset returns the state to idle and clears the entry count (list empty) and
// the result strobe; no clearing pass runs.
module ordered_list_delete_by_key import oldbk_pkg::*; #(
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [CmdW-1:0]          cmd_i,
  input  logic signed [ValueW-1:0] item_value_i,
  output logic                     strobe_o,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] element_o,
  output logic [PosW-1:0]          position_o,
  output logic                     last_o
);

  `include "ordered_list_delete_by_key_defines.svh"

  localparam int CW = $clog2(Depth + 1);
  localparam int IW = $clog2(Depth);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              strobe_q, strobe_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [ValueW-1:0] element_q, element_d;
  logic [PosW-1:0]   position_q, position_d;
  logic              last_q, last_d;

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              full;
  logic [ValueW-1:0] vals  [Depth];
  logic              hits  [Depth+1];
  logic [Depth-1:0]  first;
  logic [IW-1:0]     hit_idx;
  logic [IW+PosW-1:0] hit_idx_ext, idx_ext;

  assign accept = start && !busy;
  assign busy   = state_q == ST_SHOW;
  assign full   = count_q == CW'(Depth);

  assign ctrl.append    = accept && (cmd_i == CMD_APPEND) && !full;
  assign ctrl.delete_en = accept && (cmd_i == CMD_DELETE);
  assign ctrl.rotate    = state_q == ST_SHOW;
  assign ctrl.value     = ValueW'(item_value_i);

  assign hits[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [ValueW-1:0] next_v;
    if (i == Depth - 1) begin : g_end
      assign next_v = vals[i];
    end else begin : g_mid
      assign next_v = vals[i+1];
    end
    oldbk_cell #(
      .Depth(Depth),
      .Idx  (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .count_i(count_q),
      .next_i (next_v),
      .head_i (vals[0]),
      .hit_i  (hits[i]),
      .hit_o  (hits[i+1]),
      .first_o(first[i]),
      .value_o(vals[i])
    );
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (first[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit_idx_ext = {{PosW{1'b0}}, hit_idx};
  assign idx_ext     = {{PosW{1'b0}}, idx_q};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    strobe_d   = 1'b0;
    status_d   = status_q;
    element_d  = element_q;
    position_d = position_q;
    last_d     = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_APPEND: begin
              strobe_d   = 1'b1;
              status_d   = full ? STS_FULL : STS_APPENDED;
              element_d  = '0;
              position_d = '0;
              last_d     = 1'b1;
              if (!full) begin
                count_d = count_q + CW'(1);
              end
            end
            CMD_DELETE: begin
              strobe_d   = 1'b1;
              element_d  = '0;
              last_d     = 1'b1;
              if (hits[Depth]) begin
                status_d   = STS_DELETED;
                position_d = hit_idx_ext[PosW-1:0];
                count_d    = count_q - CW'(1);
              end else begin
                status_d   = STS_NOT_FOUND;
                position_d = '0;
              end
            end
            CMD_DISPLAY: begin
              if (count_q == '0) begin
                strobe_d   = 1'b1;
                status_d   = STS_EMPTY;
                element_d  = '0;
                position_d = '0;
                last_d     = 1'b1;
              end else begin
                state_d = ST_SHOW;
                idx_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHOW: begin
        strobe_d   = 1'b1;
        status_d   = STS_SHOWN;
        element_d  = vals[0];
        position_d = idx_ext[PosW-1:0];
        last_d     = CW'(idx_q) + CW'(1) == count_q;
        idx_d      = idx_q + IW'(1);
        if (last_d) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    status_q   <= status_d;
    element_q  <= element_d;
    position_q <= position_d;
    last_q     <= last_d;
  end

  assign strobe_o   = strobe_q;
  assign status_o   = status_q;
  assign element_o  = signed'(element_q);
  assign position_o = position_q;
  assign last_o     = last_q;

  `OLDBK_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(Depth))
  `OLDBK_ASSERT_NEXT(a_show_strobes, clk_i, rst_ni, state_q == ST_SHOW, strobe_o)
  `OLDBK_ASSERT_NOW(a_last_frees, clk_i, rst_ni,
    strobe_o && last_o && (status_o == STS_SHOWN), !busy)
  `OLDBK_ASSERT_NEXT(a_append_grows, clk_i, rst_ni, ctrl.append,
    count_q == $past(count_q) + CW'(1))

endmodule
